FILE: rtl/shift_and_string_matcher_assert.svh
// ----------------------------------------------------------------------------
// shift and string matcher assertion macros
// shared check forms, sampled on clock, off while reset is high
// ----------------------------------------------------------------------------
`ifndef SHIFT_AND_STRING_MATCHER_ASSERT_SVH
`define SHIFT_AND_STRING_MATCHER_ASSERT_SVH

// consequent holds in the same cycle
`define SASM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sasm same-cycle check failed");

// consequent holds in the next cycle
`define SASM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sasm next-cycle check failed");

`endif

FILE: rtl/sasm_pkg.sv
// ----------------------------------------------------------------------------
// sasm_pkg
// shared types, widths, register indexes and helpers of the matcher
// ----------------------------------------------------------------------------
`default_nettype none

package sasm_pkg;

   localparam int CHAR_W         = 8;
   localparam int CFG_WORD_W     = 64;
   localparam int CFG_WORDS      = 4;
   localparam int CHARS_PER_WORD = CFG_WORD_W / CHAR_W;
   localparam int PATTERN_STORE  = CFG_WORDS * CHARS_PER_WORD;
   localparam int CFG_LEN_W      = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int OFFSET_OUT_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IGNORE_CASE = 3'd5;

   localparam logic [CFG_LEN_W-1:0] LENGTH_RESET = 6'd1;

   localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_DELTA  = 8'h20;

   typedef struct packed {
      logic [CHAR_W-1:0]    text;
      logic                 start;
      logic                 fold;
      logic                 advance;
      logic [CFG_LEN_W-1:0] len;
   } cell_ctl_type;

   function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         r = c + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sasm_channels.sv
// ----------------------------------------------------------------------------
// sasm channels
// valid/ready channels for text items, result items and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface sasm_req_if import sasm_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_byte;
   logic              start_of_text;

   modport source (output valid, text_byte, start_of_text, input ready);
   modport sink (input valid, text_byte, start_of_text, output ready);
endinterface

interface sasm_rsp_if import sasm_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    match_found;
   logic                    first_match_res;
   logic [OFFSET_OUT_W-1:0] match_end_offset;
   logic [OFFSET_OUT_W-1:0] match_start_offset;

   modport source (output valid, match_found, first_match_res, match_end_offset,
                   match_start_offset, input ready);
   modport sink (input valid, match_found, first_match_res, match_end_offset,
                 match_start_offset, output ready);
endinterface

interface sasm_csr_if import sasm_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_WORD_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sasm_cell.sv
// ----------------------------------------------------------------------------
// sasm_cell
// one pattern position: compares the text byte, holds one match vector bit
// and passes it to the next position
// ----------------------------------------------------------------------------
`default_nettype none

module sasm_cell import sasm_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [CHAR_W-1:0] pattern_char,
   input  logic              carry_in,
   output logic              bit_out,
   output logic              tail_hit
);

   localparam logic [CFG_LEN_W:0] POS = (CFG_LEN_W + 1)'(INDEX + 1);

   logic bit_ff;
   logic bit_in;
   logic bit_next;
   logic shifted;
   logic in_use;
   logic char_hit;

   always_comb begin
      if (INDEX == 0) begin
         shifted = 1'b1;
      end else begin
         shifted = carry_in & ~ctl.start;
      end
      in_use   = {1'b0, ctl.len} >= POS;
      char_hit = (pattern_char == ctl.text) |
                 (ctl.fold & (fold_lower(pattern_char) == fold_lower(ctl.text)));
      bit_next = shifted & char_hit & in_use;
      tail_hit = bit_next & ({1'b0, ctl.len} == POS);
      bit_in   = ctl.advance ? bit_next : bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

`default_nettype wire

FILE: rtl/shift_and_string_matcher.sv
// ----------------------------------------------------------------------------
// shift_and_string_matcher
// shift-and exact matcher over a byte stream, one result item per text item
// result: registered, valid in the cycle after its text item is accepted
// throughput: one item per cycle while the result side takes items; a held result stalls text
// reset: match vector, offset, match flag and result valid clear;
// pattern bytes clear, length resets to one, ignore case off
// ----------------------------------------------------------------------------
`default_nettype none

module shift_and_string_matcher import sasm_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int OFFSET_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   sasm_req_if.sink        req_ch,
   sasm_rsp_if.source      rsp_ch,
   sasm_csr_if.sink        csr_ch
);

`include "shift_and_string_matcher_assert.svh"

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   logic [CFG_WORDS-1:0][CFG_WORD_W-1:0] pat_word_ff;
   logic [CFG_LEN_W-1:0]                 len_ff;
   logic                                 icase_ff;

   logic [OFFSET_BITS-1:0] off_ff;
   logic [OFFSET_BITS-1:0] off_in;
   logic                   matched_ff;
   logic                   matched_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    found_ff;
   logic                    first_ff;
   logic [OFFSET_OUT_W-1:0] end_ff;
   logic [OFFSET_OUT_W-1:0] begin_ff;

   logic                                accept;
   cell_ctl_type                        ctl;
   logic [MAX_PATTERN-1:0]              vec_q;
   logic [MAX_PATTERN-1:0]              carry;
   logic [MAX_PATTERN-1:0]              tail;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0]  pchar;

   logic                   found;
   logic                   first;
   logic [OFFSET_BITS-1:0] cur_off;
   logic                   cur_matched;
   logic [OFFSET_BITS:0]   end_plus;
   logic [OFFSET_BITS:0]   len_wide;
   logic [OFFSET_BITS:0]   begin_val;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_word_ff <= '0;
         len_ff      <= LENGTH_RESET;
         icase_ff    <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_PATTERN_0:   pat_word_ff[0] <= csr_ch.data;
            REG_PATTERN_1:   pat_word_ff[1] <= csr_ch.data;
            REG_PATTERN_2:   pat_word_ff[2] <= csr_ch.data;
            REG_PATTERN_3:   pat_word_ff[3] <= csr_ch.data;
            REG_LENGTH:      len_ff <= csr_ch.data[CFG_LEN_W-1:0];
            REG_IGNORE_CASE: icase_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // cell row
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;

   always_comb begin
      ctl.text    = req_ch.text_byte;
      ctl.start   = req_ch.start_of_text;
      ctl.fold    = icase_ff;
      ctl.advance = accept;
      ctl.len     = len_ff;
   end

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      if (i < PATTERN_STORE) begin : g_char
         assign pchar[i] =
            pat_word_ff[i / CHARS_PER_WORD][(i % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
      end else begin : g_zero
         assign pchar[i] = '0;
      end
      if (i == 0) begin : g_head
         assign carry[i] = 1'b1;
      end else begin : g_link
         assign carry[i] = vec_q[i-1];
      end
      sasm_cell #(
         .INDEX(i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .pattern_char (pchar[i]),
         .carry_in     (carry[i]),
         .bit_out      (vec_q[i]),
         .tail_hit     (tail[i])
      );
   end

   // offsets and match flags
   always_comb begin
      cur_off     = req_ch.start_of_text ? '0 : off_ff;
      cur_matched = req_ch.start_of_text ? 1'b0 : matched_ff;
      found       = |tail;
      first       = found & ~cur_matched;
      end_plus    = {1'b0, cur_off} + (OFFSET_BITS + 1)'(1);
      len_wide    = (OFFSET_BITS + 1)'(len_ff);
      if (found && end_plus >= len_wide) begin
         begin_val = end_plus - len_wide;
      end else begin
         begin_val = '0;
      end
      off_in       = off_ff;
      matched_in   = matched_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      if (accept) begin
         off_in       = (cur_off == OFF_MAX) ? cur_off : cur_off + OFFSET_BITS'(1);
         matched_in   = cur_matched | found;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff <= found;
         first_ff <= first;
         end_ff   <= OFFSET_OUT_W'(cur_off);
         begin_ff <= OFFSET_OUT_W'(begin_val);
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.match_found        = found_ff;
   assign rsp_ch.first_match_res    = first_ff;
   assign rsp_ch.match_end_offset   = end_ff;
   assign rsp_ch.match_start_offset = begin_ff;

   `SASM_ASSERT_SAME(a_first_is_match, rsp_valid_ff && first_ff, found_ff)
   `SASM_ASSERT_SAME(a_match_sets_flag, rsp_valid_ff && found_ff, matched_ff)
   `SASM_ASSERT_NEXT(a_offset_step,
      accept && !req_ch.start_of_text && off_ff != OFF_MAX,
      off_ff == $past(off_ff) + OFFSET_BITS'(1))

endmodule

`default_nettype wire
